FILE: src/spas_pkg.sv
// spectrum peak annotation stats: shared types and constants
// no dependencies
package spas_pkg;

	localparam int MAX_PEAKS = 4096;

	localparam logic [24:0] MASS_MARGIN = 25'd9472;
	localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] PCT_SAT = 16'hFFFF;
	localparam logic [14:0] PCT_SCALE = 15'd25600;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_ANNOT = 2'd1;
	localparam logic [1:0] ST_NO_PEAKS = 2'd2;

	localparam logic [2:0] REG_MIN_MASS = 3'd0;
	localparam logic [2:0] REG_PEP_MASS = 3'd1;
	localparam logic [2:0] REG_PEP_LEN = 3'd2;
	localparam logic [2:0] REG_ALL_IONS = 3'd3;
	localparam logic [2:0] REG_ION_SELECT_MASK = 3'd4;
	localparam logic [2:0] REG_ION_TYPE_COUNT = 3'd5;

	typedef struct packed {
		logic [23:0] peak_mass;
		logic [31:0] peak_intensity;
		logic        annotated;
		logic [3:0]  ion_type;
		logic [5:0]  bond_index;
		logic        last_peak;
	} peak_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] all_int;
		logic [47:0] id_int;
		logic [12:0] all_peaks;
		logic [12:0] id_peaks;
		logic [6:0]  observed_bonds;
		logic [15:0] pct_intensity;
		logic [15:0] pct_peaks;
		logic [15:0] pct_ions;
		logic [15:0] pct_bonds;
	} stats_t;

	// classified peak from front to back
	typedef struct packed {
		logic        in_window;
		logic        selected;
		logic [31:0] intensity;
		logic [5:0]  bond;
		logic        last;
	} cls_t;

	typedef enum logic [2:0] {
		BK_ACC,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

FILE: src/spas_front.sv
// front: peak acceptance and window / selection classification
// depends on spas_pkg
module spas_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spas_pkg::peak_t     in_data,
	input  logic [23:0]         min_mass,
	input  logic [23:0]         pep_mass,
	input  logic                all_ions,
	input  logic [15:0]         ion_select_mask,
	output logic                q_valid,
	input  logic                q_ready,
	output spas_pkg::cls_t      q_data
);
	// two-entry queue
	spas_pkg::cls_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	spas_pkg::cls_t c;
	logic push, pop;

	always_comb begin
		c.in_window = (in_data.peak_mass >= min_mass) &&
			({1'b0, in_data.peak_mass} + spas_pkg::MASS_MARGIN <= {1'b0, pep_mass});
		c.selected = in_data.annotated && (all_ions || ion_select_mask[in_data.ion_type]);
		c.intensity = in_data.peak_intensity;
		c.bond = in_data.bond_index;
		c.last = in_data.last_peak;
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: src/spas_back.sv
// back: accumulators, serial percentage division and result register
// depends on spas_pkg
module spas_back #(
	parameter int MAX_BONDS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  spas_pkg::cls_t      q_data,
	input  logic [6:0]          pep_len,
	input  logic [4:0]          ion_type_count,
	output logic                out_valid,
	input  logic                out_ready,
	output spas_pkg::stats_t    out_data
);
	localparam logic [12:0] CNT_MAX = 13'(spas_pkg::MAX_PEAKS);
	localparam int NUMW = 63;
	localparam int QW = 64;

	spas_pkg::bk_state_t st_q, st_d;
	logic [47:0] isum_q, esum_q;
	logic [12:0] pcnt_q, ecnt_q;
	logic [63:0] map_q;
	logic [6:0]  bonds_q;
	logic [1:0]  job_q;
	logic [6:0]  bit_q;
	logic [NUMW-1:0] num_q;
	logic [QW-1:0] rem_q;
	logic [47:0] den_q;
	logic [15:0] pct_q [4];
	spas_pkg::stats_t res_q;
	logic        out_valid_q;

	logic [48:0] isum_n, esum_n;
	logic [63:0] bset;
	logic [QW-1:0] rsh;
	logic [6:0]  pc;
	logic [6:0]  nb;
	logic [11:0] tn;
	logic [NUMW-1:0] nums [4];
	logic [47:0] dens [4];

	// times 25600 as shifts and adds
	function automatic logic [NUMW-1:0] scale(input logic [47:0] v);
		logic [NUMW-1:0] w;
		w = {15'd0, v};
		return (w << 14) + (w << 13) + (w << 10);
	endfunction

	assign nb = pep_len - 7'd1;
	assign tn = {7'd0, ion_type_count} * {5'd0, nb};
	assign isum_n = {1'b0, isum_q} + {17'd0, q_data.intensity};
	assign esum_n = {1'b0, esum_q} + {17'd0, q_data.intensity};

	always_comb begin
		bset = '0;
		if (32'(q_data.bond) < 32'(MAX_BONDS)) bset[q_data.bond] = 1'b1;
		pc = '0;
		for (int i = 0; i < 64; i++) pc = pc + {6'd0, map_q[i]};
	end

	always_comb begin
		nums[0] = scale(esum_q);
		nums[1] = scale({35'd0, ecnt_q});
		nums[2] = nums[1];
		nums[3] = scale({41'd0, bonds_q});
		dens[0] = isum_q;
		dens[1] = {35'd0, pcnt_q};
		dens[2] = (pep_len <= 7'd1) ? 48'd0 : {36'd0, tn};
		dens[3] = (pep_len <= 7'd1) ? 48'd0 : {41'd0, nb};
		rsh = {rem_q[QW-2:0], num_q[NUMW-1]};
	end

	// restoring division, one quotient bit a cycle
	logic [QW-1:0] quo_q;
	logic [QW:0] diff;
	assign diff = {1'b0, rsh} - {17'd0, den_q};

	// a waiting result holds back only the next last peak
	assign q_ready = (st_q == spas_pkg::BK_ACC) && !(out_valid_q && q_valid && q_data.last);

	always_comb begin
		st_d = st_q;
		case (st_q)
			spas_pkg::BK_ACC: if (q_valid && q_ready && q_data.last) st_d = spas_pkg::BK_DIV;
			spas_pkg::BK_DIV: if (job_q == 2'd3 && bit_q == 7'(NUMW)) st_d = spas_pkg::BK_OUT;
			spas_pkg::BK_OUT: st_d = spas_pkg::BK_ACC;
			default: st_d = spas_pkg::BK_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= spas_pkg::BK_ACC;
			isum_q <= '0;
			esum_q <= '0;
			pcnt_q <= '0;
			ecnt_q <= '0;
			map_q <= '0;
			out_valid_q <= 1'b0;
			job_q <= '0;
			bit_q <= '0;
		end else begin
			st_q <= st_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				spas_pkg::BK_ACC: begin
					if (q_valid && q_ready && q_data.in_window) begin
						isum_q <= isum_n[48] ? spas_pkg::SUM_MAX : isum_n[47:0];
						pcnt_q <= (pcnt_q >= CNT_MAX) ? CNT_MAX : pcnt_q + 13'd1;
						if (q_data.selected) begin
							esum_q <= esum_n[48] ? spas_pkg::SUM_MAX : esum_n[47:0];
							ecnt_q <= (ecnt_q >= CNT_MAX) ? CNT_MAX : ecnt_q + 13'd1;
							map_q <= map_q | bset;
						end
					end
					job_q <= '0;
					bit_q <= '0;
				end
				spas_pkg::BK_DIV: begin
					if (bit_q == 7'(NUMW)) begin
						job_q <= job_q + 2'd1;
						bit_q <= '0;
					end else begin
						bit_q <= bit_q + 7'd1;
					end
				end
				spas_pkg::BK_OUT: begin
					out_valid_q <= 1'b1;
					isum_q <= '0;
					esum_q <= '0;
					pcnt_q <= '0;
					ecnt_q <= '0;
					map_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			spas_pkg::BK_ACC: begin
				bonds_q <= pc;
			end
			spas_pkg::BK_DIV: begin
				bonds_q <= pc;
				if (bit_q == 7'd0) begin
					num_q <= nums[job_q];
					den_q <= dens[job_q];
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					num_q <= {num_q[NUMW-2:0], 1'b0};
					if (!diff[QW]) begin
						rem_q <= diff[QW-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	// final quotient visible in the cycle after the last shift
	logic [15:0] qfin;
	always_comb begin
		qfin = (den_q == 48'd0) ? 16'd0 :
			(|quo_q[QW-1:16] ? spas_pkg::PCT_SAT : quo_q[15:0]);
	end

	always_ff @(posedge clk) begin
		if (st_q == spas_pkg::BK_DIV && bit_q == 7'd0 && job_q != 2'd0) pct_q[job_q - 2'd1] <= qfin;
		if (st_q == spas_pkg::BK_OUT) begin
			if (pep_len == 7'd0) begin
				res_q <= '{status: spas_pkg::ST_NOT_ANNOT, default: '0};
			end else begin
				res_q.status <= (pcnt_q == 13'd0) ? spas_pkg::ST_NO_PEAKS : spas_pkg::ST_OK;
				res_q.all_int <= isum_q;
				res_q.id_int <= esum_q;
				res_q.all_peaks <= pcnt_q;
				res_q.id_peaks <= ecnt_q;
				res_q.observed_bonds <= bonds_q;
				res_q.pct_intensity <= pct_q[0];
				res_q.pct_peaks <= pct_q[1];
				res_q.pct_ions <= pct_q[2];
				res_q.pct_bonds <= qfin;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = res_q;
endmodule

FILE: src/spectrum_peak_annotation_stats.sv
// top level: config registers, front classifier, back accumulator/divider
// depends on spas_pkg, spas_front, spas_back
//
// channel  | handshake            | payload
// peak in  | in_valid / in_ready  | in_data  (spas_pkg::peak_t)
// stats out| out_valid / out_ready| out_data (spas_pkg::stats_t)
// config   | cfg_we               | cfg_index, cfg_data
//
// one peak per cycle into the accumulators while no division or result step runs
// a last peak starts the bit-serial division of the four percentages, then a result step;
// out_valid is set in that result step and holds until out_ready
// while dividing the back takes nothing; the two-entry queue fills, then in_ready drops
// a last peak waits in the queue while the previous result beat is not taken
// arst_n clears accumulators and config to reset values
module spectrum_peak_annotation_stats #(
	parameter int MAX_BONDS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  spas_pkg::peak_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output spas_pkg::stats_t out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data
);
	logic [23:0] min_mass_q, pep_mass_q;
	logic [6:0]  pep_len_q;
	logic        all_ions_q;
	logic [15:0] ion_select_mask_q;
	logic [4:0]  ion_type_count_q;
	logic        q_valid, q_ready;
	spas_pkg::cls_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mass_q <= 24'd14592;
			pep_mass_q <= '0;
			pep_len_q <= '0;
			all_ions_q <= 1'b1;
			ion_select_mask_q <= '0;
			ion_type_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				spas_pkg::REG_MIN_MASS: min_mass_q <= cfg_data;
				spas_pkg::REG_PEP_MASS: pep_mass_q <= cfg_data;
				spas_pkg::REG_PEP_LEN: pep_len_q <= cfg_data[6:0];
				spas_pkg::REG_ALL_IONS: all_ions_q <= cfg_data[0];
				spas_pkg::REG_ION_SELECT_MASK: ion_select_mask_q <= cfg_data[15:0];
				spas_pkg::REG_ION_TYPE_COUNT: ion_type_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	spas_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.min_mass(min_mass_q), .pep_mass(pep_mass_q),
		.all_ions(all_ions_q), .ion_select_mask(ion_select_mask_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	spas_back #(.MAX_BONDS(MAX_BONDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.pep_len(pep_len_q), .ion_type_count(ion_type_count_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_no_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(q_valid && q_ready && q_data.last))
		else $error("back took a last peak with result pending");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");
endmodule
